/* hdl/multilevel_priority_fifo_core_macros.svh */
// Assertion macros used by the priority queue back end.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MULTILEVEL_PRIORITY_FIFO_CORE_MACROS_SVH
`define MULTILEVEL_PRIORITY_FIFO_CORE_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define MPFQ_ASSERT_HOLD(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define MPFQ_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* hdl/mpfq_pkg.sv */
// Types and constants for the multilevel priority queue.
// Used by the front end, the back end and the top level; depends on nothing.
package mpfq_pkg;

  localparam int ENTRY_W   = 8;
  localparam int PRIO_W    = 3;
  localparam int CNT_OUT_W = 7;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_PRIO = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  typedef logic [1:0] op_kind_t;
  localparam op_kind_t OP_ENQ = 2'd0;
  localparam op_kind_t OP_DEQ = 2'd1;
  localparam op_kind_t OP_REJ = 2'd2;

  typedef struct packed {
    logic                mode;
    logic [PRIO_W-1:0]   priority_req;
    logic [ENTRY_W-1:0]  entry_id;
  } mpfq_in_t;

  typedef struct packed {
    status_t              status;
    logic [ENTRY_W-1:0]   removed_entry;
    logic                 head_valid;
    logic [ENTRY_W-1:0]   head_entry;
    logic [CNT_OUT_W-1:0] total_count;
  } mpfq_out_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [PRIO_W-1:0]   prio;
    logic [ENTRY_W-1:0]  id;
  } mpfq_cmd_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic      valid;
    mpfq_cmd_t cmd;
  } mpfq_q_t;

endpackage

/* hdl/mpfq_front.sv */
// Front end of the priority queue: takes items, classifies them and holds them
// in a two-entry command queue for the back end. Depends on mpfq_pkg.
module mpfq_front import mpfq_pkg::*; #(
  parameter int MAX_LEVEL = 5
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  mpfq_in_t in_item,
  output mpfq_q_t  q_head,
  input  logic     q_pop
);

  localparam int QDEPTH = 2;

  mpfq_cmd_t  q_mem_r [QDEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;
  mpfq_cmd_t  cmd;

  assign busy = (cnt_r == 2'(QDEPTH));
  assign push = start && !busy;

  // An enqueue priority above the top level is caught here and sent on as a reject.
  always_comb begin
    cmd.prio = in_item.priority_req;
    cmd.id   = in_item.entry_id;
    if (in_item.mode == MODE_DEQ) begin
      cmd.kind = OP_DEQ;
    end else if (int'(in_item.priority_req) > MAX_LEVEL) begin
      cmd.kind = OP_REJ;
    end else begin
      cmd.kind = OP_ENQ;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.cmd   = q_mem_r[rd_ptr_r];

endmodule

/* hdl/mpfq_back.sv */
// Back end of the priority queue: slot pool, per-level linked lists and the
// sequencer that executes one command at a time. Depends on mpfq_pkg and the macros.
`include "multilevel_priority_fifo_core_macros.svh"

module mpfq_back import mpfq_pkg::*; #(
  parameter int MAX_LEVEL = 5,
  parameter int CAPACITY  = 64,
  parameter int ID_WIDTH  = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  mpfq_q_t   q_head,
  output logic      q_pop,
  output logic      out_valid,
  output mpfq_out_t out_item
);

  localparam int NUM_LEVELS = MAX_LEVEL + 1;
  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = (ID_WIDTH < ENTRY_W) ? ID_WIDTH : ENTRY_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ENQ_WR   = 3'd1;
  localparam logic [2:0] S_DEQ_NEXT = 3'd2;
  localparam logic [2:0] S_DEQ_ID   = 3'd3;
  localparam logic [2:0] S_RESP     = 3'd4;

  // Slot pool memories.
  logic [SW-1:0] slot_entry_mem [CAPACITY];
  logic [AW-1:0] slot_next_mem  [CAPACITY];
  logic [AW-1:0] free_mem       [CAPACITY];

  // Per-level list state; head_id_r caches the entry of each head slot.
  logic [AW-1:0] head_r    [NUM_LEVELS];
  logic [AW-1:0] tail_r    [NUM_LEVELS];
  logic [SW-1:0] head_id_r [NUM_LEVELS];
  logic [CW-1:0] count_r   [NUM_LEVELS];
  logic [CW-1:0] total_r;

  // Freed slots go on a stack; slots never used yet come from fresh_r.
  logic [AW:0]   fsp_r;
  logic [AW:0]   fresh_r;
  logic [AW:0]   fsp_dec;

  logic [2:0]    state_r;
  logic [2:0]    state_nxt;
  logic [LW-1:0] lv_r;
  logic [AW-1:0] slot_r;
  logic          use_stack_r;
  logic [SW-1:0] id_r;
  status_t       status_r;
  logic [SW-1:0] removed_r;
  logic [AW-1:0] free_rd_r;
  logic [AW-1:0] next_rd_r;
  logic [SW-1:0] entry_rd_r;
  logic          out_valid_r;
  mpfq_out_t     out_item_r;

  logic [NUM_LEVELS-1:0] nonempty;
  logic [LW-1:0]         top_lv;
  logic                  any_q;
  logic [LW-1:0]         p_lv;
  logic [AW-1:0]         wr_slot;
  logic                  full;

  // Memory port controls.
  logic          fm_we;
  logic [AW-1:0] fm_wa;
  logic [AW-1:0] fm_wd;
  logic          fm_re;
  logic [AW-1:0] fm_ra;
  logic          sn_we;
  logic [AW-1:0] sn_wa;
  logic [AW-1:0] sn_wd;
  logic          sn_re;
  logic [AW-1:0] sn_ra;
  logic          se_we;
  logic [AW-1:0] se_wa;
  logic [SW-1:0] se_wd;
  logic          se_re;
  logic [AW-1:0] se_ra;

  always_comb begin
    top_lv = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      nonempty[i] = (count_r[i] != '0);
      if (nonempty[i]) begin
        top_lv = LW'(i);
      end
    end
  end

  assign any_q   = |nonempty;
  assign p_lv    = LW'(q_head.cmd.prio);
  assign full    = (total_r >= CW'(CAPACITY));
  assign fsp_dec = fsp_r - 1'b1;
  assign wr_slot = use_stack_r ? free_rd_r : slot_r;
  assign q_pop   = (state_r == S_IDLE) && q_head.valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          case (q_head.cmd.kind)
            OP_ENQ: begin
              state_nxt = full ? S_RESP : S_ENQ_WR;
            end
            OP_DEQ: begin
              if (!any_q || count_r[top_lv] == CW'(1)) begin
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_DEQ_NEXT;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_ENQ_WR:   state_nxt = S_RESP;
      S_DEQ_NEXT: state_nxt = S_DEQ_ID;
      S_DEQ_ID:   state_nxt = S_RESP;
      S_RESP:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    fm_we = 1'b0;
    fm_wa = fsp_r[AW-1:0];
    fm_wd = head_r[top_lv];
    fm_re = 1'b0;
    fm_ra = fsp_dec[AW-1:0];
    sn_we = 1'b0;
    sn_wa = tail_r[lv_r];
    sn_wd = wr_slot;
    sn_re = 1'b0;
    sn_ra = head_r[top_lv];
    se_we = 1'b0;
    se_wa = wr_slot;
    se_wd = id_r;
    se_re = 1'b0;
    se_ra = next_rd_r;
    case (state_r)
      S_IDLE: begin
        if (q_pop && q_head.cmd.kind == OP_ENQ && !full && fsp_r != '0) begin
          fm_re = 1'b1;
        end
        if (q_pop && q_head.cmd.kind == OP_DEQ && any_q) begin
          fm_we = 1'b1;
          sn_re = 1'b1;
        end
      end
      S_ENQ_WR: begin
        se_we = 1'b1;
        sn_we = (count_r[lv_r] != '0);
      end
      S_DEQ_NEXT: begin
        se_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fm_we) begin
      free_mem[fm_wa] <= fm_wd;
    end
    if (fm_re) begin
      free_rd_r <= free_mem[fm_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (sn_we) begin
      slot_next_mem[sn_wa] <= sn_wd;
    end
    if (sn_re) begin
      next_rd_r <= slot_next_mem[sn_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (se_we) begin
      slot_entry_mem[se_wa] <= se_wd;
    end
    if (se_re) begin
      entry_rd_r <= slot_entry_mem[se_ra];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      fsp_r       <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        count_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_RESP);
      case (state_r)
        S_IDLE: begin
          if (q_pop && q_head.cmd.kind == OP_ENQ && !full) begin
            if (fsp_r != '0) begin
              fsp_r <= fsp_dec;
            end else begin
              fresh_r <= fresh_r + 1'b1;
            end
          end
          if (q_pop && q_head.cmd.kind == OP_DEQ && any_q) begin
            fsp_r           <= fsp_r + 1'b1;
            count_r[top_lv] <= count_r[top_lv] - CW'(1);
            total_r         <= total_r - CW'(1);
          end
        end
        S_ENQ_WR: begin
          count_r[lv_r] <= count_r[lv_r] + CW'(1);
          total_r       <= total_r + CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          status_r  <= ST_OK;
          removed_r <= '0;
          case (q_head.cmd.kind)
            OP_ENQ: begin
              lv_r        <= p_lv;
              id_r        <= SW'(q_head.cmd.id);
              use_stack_r <= (fsp_r != '0);
              slot_r      <= fresh_r[AW-1:0];
              if (full) begin
                status_r <= ST_FULL;
              end
            end
            OP_DEQ: begin
              lv_r <= top_lv;
              if (any_q) begin
                removed_r <= head_id_r[top_lv];
              end else begin
                status_r <= ST_EMPTY;
              end
            end
            default: begin
              status_r <= ST_BAD_PRIO;
            end
          endcase
        end
      end
      S_ENQ_WR: begin
        // An empty level takes the new slot as its head as well.
        if (count_r[lv_r] == '0) begin
          head_r[lv_r]    <= wr_slot;
          head_id_r[lv_r] <= id_r;
        end
        tail_r[lv_r] <= wr_slot;
      end
      S_DEQ_NEXT: begin
        head_r[lv_r] <= next_rd_r;
      end
      S_DEQ_ID: begin
        head_id_r[lv_r] <= entry_rd_r;
      end
      S_RESP: begin
        out_item_r.status        <= status_r;
        out_item_r.removed_entry <= ENTRY_W'(removed_r);
        out_item_r.head_valid    <= any_q;
        out_item_r.head_entry    <= any_q ? ENTRY_W'(head_id_r[top_lv]) : '0;
        out_item_r.total_count   <= CNT_OUT_W'(total_r);
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `MPFQ_ASSERT_HOLD(a_total_cap, total_r <= CW'(CAPACITY), "queued total exceeds capacity")
  `MPFQ_ASSERT_HOLD(a_stack_le_issued, fsp_r <= fresh_r, "free stack holds unissued slots")
  `MPFQ_ASSERT_HOLD(a_total_levels, (total_r == '0) == (any_q == 1'b0), "total and levels disagree")
  `MPFQ_ASSERT_NEXT(a_resp_strobe, state_r == S_RESP, out_valid_r, "result strobe missing")
  `MPFQ_ASSERT_NEXT(a_pop_busy, q_pop, state_r != S_IDLE, "sequencer idle after pop")

endmodule

/* hdl/multilevel_priority_fifo_core.sv */
// A rejected, full or empty item or a dequeue that empties its level goes from S_IDLE
// straight to S_RESP; an enqueue passes through S_ENQ_WR, and other dequeues pass through
// S_DEQ_NEXT and S_DEQ_ID for two dependent reads of the slot memories. The sequencer
// holds one command at a time; a two-entry queue takes items meanwhile.
// Results are single-cycle strobes that the receiver cannot stall.
// Synchronous reset empties every level and returns all slots to the pool at once.
module multilevel_priority_fifo_core import mpfq_pkg::*; #(
  parameter int MAX_LEVEL = 5,
  parameter int CAPACITY  = 64,
  parameter int ID_WIDTH  = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  mpfq_in_t  in_item,
  output logic      out_valid,
  output mpfq_out_t out_item
);

  mpfq_q_t q_head;
  logic    q_pop;

  mpfq_front #(
    .MAX_LEVEL (MAX_LEVEL)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  mpfq_back #(
    .MAX_LEVEL (MAX_LEVEL),
    .CAPACITY  (CAPACITY),
    .ID_WIDTH  (ID_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* tb/tb_multilevel_priority_fifo_core.sv */
// Self-checking bench for multilevel_priority_fifo_core: drives enqueue and dequeue items
// through the start/busy handshake and checks every result strobe against a level-queue model.
// Depends on mpfq_pkg and the core RTL only.
module tb_multilevel_priority_fifo_core import mpfq_pkg::*; ();

  localparam int LEVEL_MAX    = 5;
  localparam int POOL_SIZE    = 64;
  localparam int HANDLE_W     = 8;
  localparam int RANDOM_ITEMS = 550;
  localparam int CALM_TAIL    = 70;
  localparam int STALL_LIMIT  = 1000;
  localparam int SETTLE_WAIT  = 8;

  // Tracks the queued handles per level and the results that are still owed.
  class queue_tracker;
    logic [ENTRY_W-1:0] level_fifo [LEVEL_MAX+1][$];
    int unsigned        occupancy;
    mpfq_out_t          owed_results[$];
    int unsigned        error_count;

    function int busiest_level();
      for (int lv = LEVEL_MAX; lv >= 0; lv--) begin
        if (level_fifo[lv].size() != 0) return lv;
      end
      return -1;
    endfunction

    function mpfq_out_t predict_result(mpfq_in_t req);
      mpfq_out_t res;
      int        lv;
      res = '0;
      if (req.mode == MODE_ENQ) begin
        // The priority check wins over the full check.
        if (req.priority_req > LEVEL_MAX) begin
          res.status = ST_BAD_PRIO;
        end else if (occupancy >= POOL_SIZE) begin
          res.status = ST_FULL;
        end else begin
          level_fifo[req.priority_req].push_back(req.entry_id);
          occupancy++;
          res.status = ST_OK;
        end
      end else begin
        lv = busiest_level();
        if (lv < 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status        = ST_OK;
          res.removed_entry = level_fifo[lv].pop_front();
          occupancy--;
        end
      end
      lv = busiest_level();
      if (lv >= 0) begin
        res.head_valid = 1'b1;
        res.head_entry = level_fifo[lv][0];
      end
      res.total_count = CNT_OUT_W'(occupancy);
      return res;
    endfunction

    function void note_request(mpfq_in_t req);
      owed_results.push_back(predict_result(req));
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        error_count++;
      end
    endfunction

    function void check_result(mpfq_out_t got);
      mpfq_out_t want;
      if (owed_results.size() == 0) begin
        $error("result strobe with no item outstanding");
        error_count++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("removed_entry", want.removed_entry, got.removed_entry);
      compare_field("head_valid", want.head_valid, got.head_valid);
      compare_field("head_entry", want.head_entry, got.head_entry);
      compare_field("total_count", want.total_count, got.total_count);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  mpfq_in_t  in_item = '0;
  logic      out_valid;
  mpfq_out_t out_item;

  queue_tracker tracker = new();
  int unsigned  quiet_cycles = 0;
  int unsigned  random_sent = 0;

  multilevel_priority_fifo_core #(
    .MAX_LEVEL(LEVEL_MAX),
    .CAPACITY (POOL_SIZE),
    .ID_WIDTH (HANDLE_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_result(out_item);
  end

  // Ends the run if neither side moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_multilevel_priority_fifo_core: done, errors");
      $finish;
    end
  end

  function automatic mpfq_in_t make_item(logic mode, int prio, int handle);
    mpfq_in_t it;
    it.mode         = mode;
    it.priority_req = PRIO_W'(prio);
    it.entry_id     = ENTRY_W'(handle);
    return it;
  endfunction

  // Fields that a dequeue ignores are still randomised.
  function automatic mpfq_in_t random_item(int enq_pct);
    int prio;
    if ($urandom_range(9) == 0) prio = $urandom_range(7, LEVEL_MAX + 1);
    else prio = $urandom_range(LEVEL_MAX);
    return make_item(($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ, prio,
                     $urandom_range(255));
  endfunction

  // Called at a rising edge; returns at the edge that takes the item or after an idle gap.
  task automatic send_item(mpfq_in_t it, bit may_idle);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    tracker.note_request(it);
    if (may_idle && $urandom_range(4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(11, 1)) @(posedge clk);
    end
  endtask

  task automatic send_random(int enq_pct, bit idle_on);
    send_item(random_item(enq_pct), idle_on && (random_sent < RANDOM_ITEMS - CALM_TAIL));
    random_sent++;
  endtask

  initial begin
    int  kind;
    int  span;
    int  extra;
    bit  idle_on;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty queue, bad priorities, every level, handle extremes, drain past empty.
    send_item(make_item(MODE_DEQ, 7, 255), 1'b0);
    send_item(make_item(MODE_ENQ, 6, 8'h11), 1'b0);
    send_item(make_item(MODE_ENQ, 7, 8'hFF), 1'b1);
    send_item(make_item(MODE_ENQ, 0, 8'h00), 1'b0);
    send_item(make_item(MODE_ENQ, 2, 8'h5A), 1'b0);
    send_item(make_item(MODE_ENQ, 1, 8'hA5), 1'b1);
    send_item(make_item(MODE_ENQ, 5, 8'hFF), 1'b0);
    send_item(make_item(MODE_ENQ, 3, 8'h01), 1'b0);
    send_item(make_item(MODE_ENQ, 4, 8'h80), 1'b0);
    send_item(make_item(MODE_ENQ, 5, 8'h7F), 1'b0);
    send_item(make_item(MODE_ENQ, 0, 8'hFE), 1'b1);
    for (int i = 0; i < 9; i++) send_item(make_item(MODE_DEQ, i % 8, 255 - i), i % 3 == 0);
    send_item(make_item(MODE_DEQ, 0, 0), 1'b0);

    // Random: segments that fill to the pool limit, drain past empty, or mix freely.
    while (random_sent < RANDOM_ITEMS) begin
      kind    = $urandom_range(2);
      idle_on = $urandom_range(1);
      span    = 0;
      extra   = 0;
      if (kind == 0) begin
        while (extra < 4 && span < 200 && random_sent < RANDOM_ITEMS) begin
          send_random(85, idle_on);
          span++;
          if (tracker.occupancy == POOL_SIZE) extra++;
        end
      end else if (kind == 1) begin
        while (extra < 4 && span < 200 && random_sent < RANDOM_ITEMS) begin
          send_random(15, idle_on);
          span++;
          if (tracker.occupancy == 0) extra++;
        end
      end else begin
        repeat ($urandom_range(60, 20)) begin
          if (random_sent < RANDOM_ITEMS) send_random(50, idle_on);
        end
      end
    end
    start <= 1'b0;

    while (tracker.owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (tracker.error_count == 0) begin
      $display("tb_multilevel_priority_fifo_core: done, clean");
    end else begin
      $display("tb_multilevel_priority_fifo_core: done, errors");
    end
    $finish;
  end

endmodule

/* multilevel_priority_fifo_core.f */
+incdir+hdl
hdl/mpfq_pkg.sv
hdl/mpfq_front.sv
hdl/mpfq_back.sv
hdl/multilevel_priority_fifo_core.sv
tb/tb_multilevel_priority_fifo_core.sv
